[rtl/plcm_pkg.sv]
package plcm_pkg;

	localparam int SMP_W    = 8;
	localparam int CH_W     = 8;
	localparam int N_CH     = 3;
	localparam int REM_W    = 8;
	localparam int NUM_W    = 7;
	localparam int QUO_W    = 7;
	localparam int SEG_W    = 3;
	localparam int D1_STEPS = 3;
	localparam int D2_STEPS = 7;
	localparam int PROD_W   = REM_W + CH_W;

	localparam logic [SEG_W-1:0] SEG_LAST = 3'd4;
	localparam logic [CH_W-1:0]  WHITE    = 8'd255;

	typedef enum logic [0:0] {
		CFG_MIN_VALUE = 1'b0,
		CFG_MAX_VALUE = 1'b1
	} cfg_idx_t;

	// One restoring-division lane: partial remainder, numerator bits still to
	// shift in (msb first), quotient bits so far.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] num;
		logic [QUO_W-1:0] quo;
	} lane_t;

	typedef lane_t [N_CH-1:0] lane3_t;

	typedef struct packed {
		logic                       white;
		logic                       last;
		logic [REM_W-1:0]           span;
		logic [N_CH-1:0][CH_W-1:0]  lower;
		logic [N_CH-1:0]            neg;
	} side_t;

	// Knot colours packed blue, green, red from the top down.
	function automatic logic [N_CH*CH_W-1:0] knot_rgb(input logic [SEG_W-1:0] idx);
		logic [N_CH*CH_W-1:0] c;
		case (idx)
			3'd0:    c = {8'd128, 8'd0,   8'd0};
			3'd1:    c = {8'd255, 8'd128, 8'd0};
			3'd2:    c = {8'd128, 8'd255, 8'd128};
			3'd3:    c = {8'd0,   8'd128, 8'd255};
			3'd4:    c = {8'd0,   8'd0,   8'd128};
			default: c = {8'd0,   8'd0,   8'd128};
		endcase
		return c;
	endfunction

endpackage

[rtl/plcm_div_cell.sv]
module plcm_div_cell
	import plcm_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [REM_W-1:0] span,
	input  lane_t            lane_i,
	output lane_t            lane_o
);

	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic           fits;
	lane_t          nxt;

	// Shift in the next numerator bit, subtract the divisor where it fits.
	always_comb begin
		trial = {lane_i.rem, lane_i.num[NUM_W-1]};
		diff  = trial - {1'b0, span};
		fits  = (trial >= {1'b0, span});
		nxt.rem = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
		nxt.num = {lane_i.num[NUM_W-2:0], 1'b0};
		nxt.quo = {lane_i.quo[QUO_W-2:0], fits};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_o <= nxt;
		end
	end

endmodule

[rtl/plcm_knot.sv]
module plcm_knot
	import plcm_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  side_t  side_i,
	input  lane_t  lane_i,
	output side_t  side_s5,
	output lane3_t lanes_s5
);

	logic [SEG_W-1:0]      seg;
	logic [N_CH*CH_W-1:0]  rgb_lo;
	logic [N_CH*CH_W-1:0]  rgb_hi;
	side_t                 side_d;
	lane3_t                lanes_d;
	logic [N_CH-1:0][CH_W:0]    dif;
	logic [N_CH-1:0][CH_W:0]    mag9;
	logic [N_CH-1:0][PROD_W-1:0] prod;

	assign seg    = lane_i.quo[SEG_W-1:0];
	assign rgb_lo = knot_rgb(seg);
	assign rgb_hi = knot_rgb(seg + 3'd1);

	always_comb begin
		side_d      = side_i;
		side_d.last = (side_i.span == '0) || (seg >= SEG_LAST);
		for (int c = 0; c < N_CH; c++) begin
			dif[c]  = {1'b0, rgb_hi[c*CH_W +: CH_W]} - {1'b0, rgb_lo[c*CH_W +: CH_W]};
			mag9[c] = dif[c][CH_W] ? (~dif[c] + 9'd1) : dif[c];
			prod[c] = PROD_W'(lane_i.rem) * PROD_W'(mag9[c][CH_W-1:0]);
			side_d.lower[c] = rgb_lo[c*CH_W +: CH_W];
			side_d.neg[c]   = dif[c][CH_W];
			// Quotient stays below 128, so the top byte is already below span.
			lanes_d[c].rem = prod[c][PROD_W-2 -: REM_W];
			lanes_d[c].num = prod[c][NUM_W-1:0];
			lanes_d[c].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5  <= side_d;
			lanes_s5 <= lanes_d;
		end
	end

endmodule

[rtl/piecewise_linear_colormap.sv]
// Pipeline: 13 register stages; an accepted word moves through them in order
// to the output register, which holds it until m_tready takes it.
// Throughput: one word per cycle unless m_tready stalls the output, set by the
// cells (3 for the segment, 7 per channel for the fraction), one per stage.
// Reset (arst_n low, asynchronous): all stages empty, min_value = 0,
// max_value = 255.
module piecewise_linear_colormap
	import plcm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_idx,
	input  logic [SMP_W-1:0]     cfg_data,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [SMP_W-1:0]     s_tdata,   // [7:0] sample
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [N_CH*CH_W-1:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

	localparam int N_STG   = 1 + D1_STEPS + 1 + D2_STEPS + 1;
	localparam int KNOT_ST = 1 + D1_STEPS;
	localparam int OUT_ST  = N_STG - 1;

	// Configuration registers.
	logic [SMP_W-1:0] min_q;
	logic [SMP_W-1:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_MIN_VALUE: min_q <= cfg_data;
				CFG_MAX_VALUE: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage valids and the load-enable chain: a stage loads when it is empty
	// or its successor loads too, so bubbles collapse and the input keeps
	// taking words while the output register waits.
	logic [N_STG-1:0] vld_q;
	logic [N_STG-1:0] vld_in;
	logic [N_STG:0]   take;

	always_comb begin
		take[N_STG] = m_tready;
		for (int i = N_STG - 1; i >= 0; i--) begin
			take[i] = !vld_q[i] || take[i+1];
		end
	end

	// Valid bit each stage would load: its predecessor's, or the input's.
	assign vld_in = {vld_q[N_STG-2:0], s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < N_STG; i++) begin
				if (take[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	assign s_tready = take[0];
	assign m_tvalid = vld_q[OUT_ST];

	// Front stage: clamp the sample, form span and four times the offset, flag zero as white.
	logic [SMP_W-1:0] hi_eff;
	logic [SMP_W-1:0] s_clamp;
	logic [SMP_W-1:0] offs;
	logic [SMP_W+1:0] rem4;
	side_t            side_d0;
	lane_t            lane_d0;

	always_comb begin
		hi_eff  = (max_q < min_q) ? min_q : max_q;
		s_clamp = (s_tdata < min_q) ? min_q : ((s_tdata > hi_eff) ? hi_eff : s_tdata);
		offs    = s_clamp - min_q;
		rem4    = {offs, 2'b00};
		side_d0       = '0;
		side_d0.white = (s_tdata == '0);
		side_d0.span  = hi_eff - min_q;
		// The segment index is below 8, so start with the bits above it.
		lane_d0.rem = {1'b0, rem4[SMP_W+1 -: REM_W-1]};
		lane_d0.num = {rem4[D1_STEPS-1:0], {(NUM_W-D1_STEPS){1'b0}}};
		lane_d0.quo = '0;
	end

	side_t side_d1 [0:D1_STEPS];
	lane_t lane_d1 [0:D1_STEPS];

	always_ff @(posedge clk) begin
		if (take[0]) begin
			side_d1[0] <= side_d0;
			lane_d1[0] <= lane_d0;
		end
	end

	// Segment division: rem4 / span, one quotient bit per cell.
	for (genvar k = 1; k <= D1_STEPS; k++) begin : g_d1
		plcm_div_cell u_cell (
			.clk    (clk),
			.en     (take[k]),
			.span   (side_d1[k-1].span),
			.lane_i (lane_d1[k-1]),
			.lane_o (lane_d1[k])
		);

		always_ff @(posedge clk) begin
			if (take[k]) begin
				side_d1[k] <= side_d1[k-1];
			end
		end
	end

	// Knot lookup and the rem * |diff| products.
	side_t  side_d2  [0:D2_STEPS];
	lane3_t lanes_d2 [0:D2_STEPS];

	plcm_knot u_knot (
		.clk      (clk),
		.en       (take[KNOT_ST]),
		.side_i   (side_d1[D1_STEPS]),
		.lane_i   (lane_d1[D1_STEPS]),
		.side_s5  (side_d2[0]),
		.lanes_s5 (lanes_d2[0])
	);

	// Fraction division: three channel lanes side by side in each stage.
	for (genvar k = 1; k <= D2_STEPS; k++) begin : g_d2
		for (genvar c = 0; c < N_CH; c++) begin : g_ch
			plcm_div_cell u_cell (
				.clk    (clk),
				.en     (take[KNOT_ST+k]),
				.span   (side_d2[k-1].span),
				.lane_i (lanes_d2[k-1][c]),
				.lane_o (lanes_d2[k][c])
			);
		end

		always_ff @(posedge clk) begin
			if (take[KNOT_ST+k]) begin
				side_d2[k] <= side_d2[k-1];
			end
		end
	end

	// Final stage: apply the floor for falling channels, then white and the
	// last-knot override.
	side_t                     side_f;
	lane3_t                    lanes_f;
	logic [N_CH*CH_W-1:0]      rgb_last;
	logic [N_CH*CH_W-1:0]      rgb_d;
	logic [N_CH-1:0][CH_W:0]   v9;
	logic [N_CH*CH_W-1:0]      out_s13;

	assign side_f   = side_d2[D2_STEPS];
	assign lanes_f  = lanes_d2[D2_STEPS];
	assign rgb_last = knot_rgb(SEG_LAST);

	always_comb begin
		for (int c = 0; c < N_CH; c++) begin
			if (side_f.neg[c]) begin
				v9[c] = {1'b0, side_f.lower[c]} - {2'b00, lanes_f[c].quo}
					- {{CH_W{1'b0}}, (lanes_f[c].rem != '0)};
			end else begin
				v9[c] = {1'b0, side_f.lower[c]} + {2'b00, lanes_f[c].quo};
			end
			if (side_f.white) begin
				rgb_d[c*CH_W +: CH_W] = WHITE;
			end else if (side_f.last) begin
				rgb_d[c*CH_W +: CH_W] = rgb_last[c*CH_W +: CH_W];
			end else begin
				rgb_d[c*CH_W +: CH_W] = v9[c][CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take[OUT_ST]) begin
			out_s13 <= rgb_d;
		end
	end

	assign m_tdata = out_s13;

`ifndef SYNTHESIS
	// Segment quotient must stay within five knots and leave a proper remainder.
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[D1_STEPS] && !side_d1[D1_STEPS].white && side_d1[D1_STEPS].span != '0)
		|-> (lane_d1[D1_STEPS].quo[SEG_W-1:0] <= SEG_LAST
			&& lane_d1[D1_STEPS].quo[QUO_W-1:SEG_W] == '0
			&& lane_d1[D1_STEPS].rem < side_d1[D1_STEPS].span))
		else $error("segment division out of range");

	// Fraction remainders stay below span on every interpolated channel.
	a_frac_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[OUT_ST-1] && !side_f.white && !side_f.last)
		|-> (lanes_f[0].rem < side_f.span && lanes_f[1].rem < side_f.span
			&& lanes_f[2].rem < side_f.span))
		else $error("fraction division remainder not below span");

	// Input back-pressure only when every stage is full and the output stalls.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && (&vld_q)))
		else $error("input stalled without a full pipeline");
`endif

endmodule
